/* src/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared codes and types for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   // request kinds
   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_DROP   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // result codes
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_NO_SPACE  = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_ZERO_SIZE = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_INS_SH,
      ST_INS_WR,
      ST_DEL_SH,
      ST_RESP
   } state_type;

endpackage

/* src/first_fit_block_allocator.sv */
// A zero-size, full-table, clear or unused request and a drop on an empty table go
// straight to the result; an allocate scans the table and the room after it, then shifts
// entries up and writes, and a drop scans and shifts down, one table entry read per cycle.
// One item is in work at a time; the next is taken in the cycle after its result is
// loaded, and a finished result waits in the output register.
// Reset (synchronous): empty table, capacity 65536, no result pending.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over one pool, block table kept in address order.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS  = 64,
   parameter int OFFSET_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [OFFSET_BITS:0]    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op,
   input  logic [OFFSET_BITS:0]    req_alloc_size,
   input  logic [OFFSET_BITS-1:0]  req_block_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OFFSET_BITS-1:0]  rsp_granted_offset,
   output logic [2:0]              rsp_status
);
   import ffa_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int EW = OFFSET_BITS + 2;
   localparam int DW = 2 * OFFSET_BITS + 1;

   state_type             state_ff, state_in;
   logic [OFFSET_BITS:0]  cap_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         ptr_ff, ptr_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [EW-1:0]         edge_ff, edge_in;
   op_type                op_ff, op_in;
   logic [OFFSET_BITS:0]  size_ff, size_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   status_type            stat_ff, stat_in;
   logic [OFFSET_BITS-1:0] grant_ff, grant_in;
   logic                  rsp_valid_ff;
   logic [OFFSET_BITS-1:0] rsp_grant_ff;
   status_type            rsp_stat_ff;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic [DW-1:0]         rd_data;
   logic [OFFSET_BITS-1:0] ent_start;
   logic [OFFSET_BITS:0]  ent_len;
   logic [EW-1:0]         cap_eff, s_ext, size_ext, ent_end;
   logic                  last_ent, fit_here, fit_tail, rsp_load, req_take;

   ffa_mem #(.DEPTH(MAX_BLOCKS), .WIDTH(DW), .AW(IW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   // entry fields and fit checks
   always_comb begin
      ent_start = rd_data[DW-1 -: OFFSET_BITS];
      ent_len   = rd_data[OFFSET_BITS:0];
      if (cap_ff > {1'b1, {OFFSET_BITS{1'b0}}}) begin
         cap_eff = EW'({1'b1, {OFFSET_BITS{1'b0}}});
      end else begin
         cap_eff = EW'(cap_ff);
      end
      s_ext    = EW'(ent_start);
      size_ext = EW'(size_ff);
      ent_end  = s_ext + EW'(ent_len);
      last_ent = (CW'(ptr_ff) + CW'(1)) == cnt_ff;
      fit_here = (s_ext >= edge_ff) && ((s_ext - edge_ff) >= size_ext)
                 && ((edge_ff + size_ext) <= cap_eff);
      fit_tail = (cap_eff >= edge_ff) && ((cap_eff - edge_ff) >= size_ext);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      edge_in  = edge_ff;
      op_in    = op_ff;
      size_in  = size_ff;
      off_in   = off_ff;
      stat_in  = stat_ff;
      grant_in = grant_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = rd_data;
      case (state_ff)
         ST_IDLE: begin
            ptr_in = '0;
            if (req_take) begin
               op_in    = op_type'(req_op);
               size_in  = req_alloc_size;
               off_in   = req_block_offset;
               edge_in  = '0;
               grant_in = '0;
               stat_in  = STAT_OK;
               state_in = ST_RESP;
               case (op_type'(req_op))
                  OP_ALLOC: begin
                     if (req_alloc_size == '0) begin
                        stat_in = STAT_ZERO_SIZE;
                     end else if (cnt_ff == CW'(MAX_BLOCKS)) begin
                        stat_in = STAT_FULL;
                     end else if (cnt_ff == '0) begin
                        state_in = ST_TAIL;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_DROP: begin
                     if (cnt_ff == '0) begin
                        stat_in = STAT_NOT_FOUND;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // walk the table, one entry per cycle
         ST_SCAN: begin
            if (op_ff == OP_ALLOC) begin
               if (fit_here) begin
                  pos_in   = ptr_ff;
                  ptr_in   = IW'(cnt_ff - CW'(1));
                  state_in = ST_INS_SH;
               end else begin
                  if (ent_end > edge_ff) begin
                     edge_in = ent_end;
                  end
                  if (last_ent) begin
                     state_in = ST_TAIL;
                  end else begin
                     ptr_in = ptr_ff + IW'(1);
                  end
               end
            end else begin
               if (ent_start == off_ff) begin
                  pos_in = ptr_ff;
                  if (last_ent) begin
                     cnt_in   = cnt_ff - CW'(1);
                     state_in = ST_RESP;
                  end else begin
                     ptr_in   = ptr_ff + IW'(1);
                     state_in = ST_DEL_SH;
                  end
               end else if (last_ent) begin
                  stat_in  = STAT_NOT_FOUND;
                  state_in = ST_RESP;
               end else begin
                  ptr_in = ptr_ff + IW'(1);
               end
            end
         end
         // room after the last block
         ST_TAIL: begin
            if (fit_tail) begin
               pos_in   = IW'(cnt_ff);
               state_in = ST_INS_WR;
            end else begin
               stat_in  = STAT_NO_SPACE;
               state_in = ST_RESP;
            end
         end
         // move entries up by one, from the top down
         ST_INS_SH: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + IW'(1);
            if (ptr_ff == pos_ff) begin
               state_in = ST_INS_WR;
            end else begin
               ptr_in = ptr_ff - IW'(1);
            end
         end
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = {edge_ff[OFFSET_BITS-1:0], size_ff};
            cnt_in   = cnt_ff + CW'(1);
            grant_in = edge_ff[OFFSET_BITS-1:0];
            state_in = ST_RESP;
         end
         // move entries down by one, from the gap up
         ST_DEL_SH: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - IW'(1);
            if (last_ent) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_RESP;
            end else begin
               ptr_in = ptr_ff + IW'(1);
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= {1'b1, {OFFSET_BITS{1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      edge_ff  <= edge_in;
      op_ff    <= op_in;
      size_ff  <= size_in;
      off_ff   <= off_in;
      stat_ff  <= stat_in;
      grant_ff <= grant_in;
      if (rsp_load) begin
         rsp_grant_ff <= (stat_ff == STAT_OK) ? grant_ff : '0;
         rsp_stat_ff  <= stat_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_grant_ff;
   assign rsp_status         = rsp_stat_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_BLOCKS))
      else $error("block count above table depth");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("table write while idle");

   a_ins_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_SH) |-> (ptr_ff >= pos_ff))
      else $error("insert shift passed its slot");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("result load did not return to idle");

endmodule

/* src/ffa_mem.sv */
// ----------------------------------------------------------------------------
// ffa_mem
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 33,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
